// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dht_pkg.sv =====
`timescale 1ns / 1ps
package dht_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int MAX_NAME_DEF = 64;
    localparam int CFG_W        = 7;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 7'd64;
    localparam int BYTE_W       = 7;
    localparam int POS_W        = 6;

    typedef enum logic [1:0] {
        K_INSERT  = 2'd0,
        K_SEARCH  = 2'd1,
        K_REMOVE  = 2'd2,
        K_UNKNOWN = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_INSERTED  = 3'd0,
        R_FULL      = 3'd1,
        R_FOUND     = 3'd2,
        R_NOT_FOUND = 3'd3,
        R_REMOVED   = 3'd4,
        R_TOO_LONG  = 3'd5
    } t_res;

    typedef enum logic [1:0] {
        SS_EMPTY = 2'd0,
        SS_USED  = 2'd1,
        SS_GONE  = 2'd2
    } t_slot;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_MOD, B_RD, B_CHK, B_CMP, B_CMPC, B_CPY, B_CPYW, B_DONE
    } t_bstate;

    // Queue fill state seen by the front and back ends.
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_q_stat;

endpackage

// ===== rtl/dht_ram.sv =====
`timescale 1ns / 1ps
module dht_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dht_front.sv =====
`timescale 1ns / 1ps
module dht_front
    import dht_pkg::*;
#(
    parameter int MAX_NAME = MAX_NAME_DEF,
    parameter int KEY_W    = 13,
    parameter int CNT_W    = 7,
    parameter int NB_W     = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  t_kind             i_kind,
    input  t_q_stat           i_qstat,
    input  logic              i_bank,
    input  logic              i_clearing,
    output logic              o_push,
    output t_kind             o_kind,
    output logic [KEY_W-1:0]  o_key,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_over,
    output logic              o_buf_we,
    output logic [NB_W-1:0]   o_buf_waddr,
    output logic [BYTE_W-1:0] o_buf_wdata
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_over, n_over;
    logic             accept;

    assign o_ready     = i_qstat.not_full && !i_clearing;
    assign accept      = i_valid && o_ready;
    assign o_buf_waddr = NB_W'(int'(i_bank) * MAX_NAME + int'(r_count));
    assign o_buf_wdata = i_byte;

    // Collect bytes into the free bank and hand a command on at the last one.
    always_comb begin
        n_count  = r_count;
        n_key    = r_key;
        n_over   = r_over;
        o_buf_we = 1'b0;
        if (accept) begin
            if (r_count < CNT_W'(MAX_NAME)) begin
                o_buf_we = 1'b1;
                n_count  = r_count + CNT_W'(1);
                n_key    = r_key + KEY_W'(i_byte);
            end else begin
                n_over = 1'b1;
            end
        end
        o_push  = accept && i_last;
        o_kind  = i_kind;
        o_key   = n_key;
        o_count = n_count;
        o_over  = n_over;
        if (o_push) begin
            n_count = '0;
            n_key   = '0;
            n_over  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_key   <= '0;
            r_over  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_key   <= n_key;
            r_over  <= n_over;
        end
    end

endmodule

// ===== rtl/dht_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dht_queue
    import dht_pkg::*;
#(
    parameter int KEY_W = 13,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_kind            i_kind,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_over,
    input  logic             i_pop,
    output t_q_stat          o_stat,
    output logic             o_wr_bank,
    output logic             o_rd_bank,
    output t_kind            o_kind,
    output logic [KEY_W-1:0] o_key,
    output logic [CNT_W-1:0] o_count,
    output logic             o_over
);

    // Two entries; an entry's place is also the name buffer bank it owns.
    t_kind            r_kind  [2];
    logic [KEY_W-1:0] r_key   [2];
    logic [CNT_W-1:0] r_len   [2];
    logic             r_ovf   [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_kind[r_wr] <= i_kind;
            r_key[r_wr]  <= i_key;
            r_len[r_wr]  <= i_count;
            r_ovf[r_wr]  <= i_over;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_stat.not_empty = (r_cnt != 2'd0);
    assign o_stat.not_full  = (r_cnt != 2'd2);
    assign o_wr_bank        = r_wr;
    assign o_rd_bank        = r_rd;
    assign o_kind           = r_kind[r_rd];
    assign o_key            = r_key[r_rd];
    assign o_count          = r_len[r_rd];
    assign o_over           = r_ovf[r_rd];

    `AST_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !i_push, "push into full queue")
    `AST_IMP(a_no_underflow, i_clk, i_rst_n, r_cnt == 2'd0, !i_pop, "pop from empty queue")

endmodule

// ===== rtl/dht_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dht_back
    import dht_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int MAX_NAME = MAX_NAME_DEF,
    parameter int KEY_W    = 13,
    parameter int CNT_W    = 7,
    parameter int NB_W     = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_W-1:0]  i_table_size,
    input  t_q_stat           i_qstat,
    input  t_kind             i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_over,
    input  logic              i_rd_bank,
    output logic              o_pop,
    output logic              o_clearing,
    output logic [NB_W-1:0]   o_buf_raddr,
    input  logic [BYTE_W-1:0] i_buf_rdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata
);

    localparam int SI_W = $clog2(SLOTS);
    localparam int SW   = $clog2(SLOTS + 1);
    localparam int MW   = (SW > CFG_W) ? SW : CFG_W;
    localparam int CA_W = $clog2(SLOTS * MAX_NAME);
    localparam int BW   = $clog2(KEY_W);

    t_bstate          r_state, n_state;
    logic [SI_W-1:0]  r_clr, n_clr;
    logic [BW-1:0]    r_bit, n_bit;
    logic [SW-1:0]    r_rem_a, n_rem_a, r_rem_b, n_rem_b;
    logic [SI_W-1:0]  r_j, n_j, r_stride, n_stride, r_i, n_i;
    logic [CNT_W-1:0] r_c, n_c;
    t_res             r_res, n_res;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_out_valid, n_out_valid;
    t_res             r_out_res, n_out_res;
    logic [POS_W-1:0] r_out_pos, n_out_pos;

    logic [MW-1:0]    ts;
    logic [SW-1:0]    m;
    logic [SW:0]      t_a, t_b, d_a, d_b;
    logic [SI_W:0]    adv_sum;
    logic [SI_W-1:0]  adv_j;
    logic             last_probe;
    t_res             miss_res;

    logic             st_we, len_we, ch_we;
    logic [SI_W-1:0]  st_waddr;
    logic [1:0]       st_wdata, st_rdata;
    logic [CNT_W-1:0] len_rdata;
    logic [CA_W-1:0]  ch_addr;
    logic [BYTE_W-1:0] ch_rdata;

    // Slot state, stored lengths and stored characters.
    dht_ram #(.W(2), .D(SLOTS)) u_status (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(r_j), .o_rdata(st_rdata)
    );
    dht_ram #(.W(CNT_W), .D(SLOTS)) u_length (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(r_j), .i_wdata(i_count),
        .i_raddr(r_j), .o_rdata(len_rdata)
    );
    dht_ram #(.W(BYTE_W), .D(SLOTS * MAX_NAME)) u_chars (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_addr), .i_wdata(i_buf_rdata),
        .i_raddr(ch_addr), .o_rdata(ch_rdata)
    );

    // Table size in use, clamped to the range the storage supports.
    always_comb begin
        ts = MW'(i_table_size);
        if (ts < MW'(2)) begin
            m = SW'(2);
        end else if (ts > MW'(SLOTS)) begin
            m = SW'(SLOTS);
        end else begin
            m = SW'(ts);
        end
    end

    // One restoring step of both remainders, and the next probe slot.
    assign t_a        = {r_rem_a, i_key[r_bit]};
    assign t_b        = {r_rem_b, i_key[r_bit]};
    assign d_a        = (SW + 1)'(m);
    assign d_b        = (SW + 1)'(m - SW'(1));
    assign adv_sum    = (SI_W + 1)'(r_j) + (SI_W + 1)'(r_stride);
    assign adv_j      = (adv_sum >= (SI_W + 1)'(m)) ? SI_W'(adv_sum - (SI_W + 1)'(m))
                                                    : SI_W'(adv_sum);
    assign last_probe = (SW'(r_i) == m - SW'(1));
    assign ch_addr    = CA_W'(int'(r_j) * MAX_NAME + int'(r_c));
    assign o_buf_raddr = NB_W'(int'(i_rd_bank) * MAX_NAME + int'(r_c));
    assign o_clearing = (r_state == B_CLEAR);

    always_comb begin
        unique case (i_kind)
            K_INSERT: miss_res = R_FULL;
            K_REMOVE: miss_res = R_REMOVED;
            default:  miss_res = R_NOT_FOUND;
        endcase
    end

    // Probe sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_bit       = r_bit;
        n_rem_a     = r_rem_a;
        n_rem_b     = r_rem_b;
        n_j         = r_j;
        n_stride    = r_stride;
        n_i         = r_i;
        n_c         = r_c;
        n_res       = r_res;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_res   = r_out_res;
        n_out_pos   = r_out_pos;
        o_pop       = 1'b0;
        st_we       = 1'b0;
        st_waddr    = r_j;
        st_wdata    = SS_EMPTY;
        len_we      = 1'b0;
        ch_we       = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                n_clr    = r_clr + SI_W'(1);
                if (r_clr == SI_W'(SLOTS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_qstat.not_empty) begin
                    n_pos = '0;
                    if (i_over) begin
                        n_res   = R_TOO_LONG;
                        n_state = B_DONE;
                    end else if (i_kind == K_UNKNOWN) begin
                        n_res   = R_NOT_FOUND;
                        n_state = B_DONE;
                    end else begin
                        n_rem_a = '0;
                        n_rem_b = '0;
                        n_bit   = BW'(KEY_W - 1);
                        n_state = B_MOD;
                    end
                end
            end
            B_MOD: begin
                n_rem_a = SW'((t_a >= d_a) ? t_a - d_a : t_a);
                n_rem_b = SW'((t_b >= d_b) ? t_b - d_b : t_b);
                n_bit   = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_j      = SI_W'(n_rem_a);
                    n_stride = SI_W'(n_rem_b) + SI_W'(1);
                    n_i      = '0;
                    n_state  = B_RD;
                end
            end
            B_RD: begin
                n_state = B_CHK;
            end
            B_CHK: begin
                n_c = '0;
                if (i_kind == K_INSERT && st_rdata != SS_USED) begin
                    n_state = B_CPY;
                end else if (i_kind != K_INSERT && st_rdata == SS_EMPTY) begin
                    n_res   = miss_res;
                    n_state = B_DONE;
                end else if (i_kind != K_INSERT && st_rdata == SS_USED
                             && len_rdata == i_count) begin
                    n_state = B_CMP;
                end else if (last_probe) begin
                    n_res   = miss_res;
                    n_state = B_DONE;
                end else begin
                    n_i     = r_i + SI_W'(1);
                    n_j     = adv_j;
                    n_state = B_RD;
                end
            end
            B_CMP: begin
                n_state = B_CMPC;
            end
            B_CMPC: begin
                if (ch_rdata == i_buf_rdata && r_c != i_count - CNT_W'(1)) begin
                    n_c     = r_c + CNT_W'(1);
                    n_state = B_CMP;
                end else if (ch_rdata == i_buf_rdata && i_kind == K_SEARCH) begin
                    n_res   = R_FOUND;
                    n_pos   = POS_W'(r_j);
                    n_state = B_DONE;
                end else begin
                    // Whole match on remove retires the slot; both go on probing.
                    if (ch_rdata == i_buf_rdata) begin
                        st_we    = 1'b1;
                        st_wdata = SS_GONE;
                    end
                    if (last_probe) begin
                        n_res   = miss_res;
                        n_state = B_DONE;
                    end else begin
                        n_i     = r_i + SI_W'(1);
                        n_j     = adv_j;
                        n_state = B_RD;
                    end
                end
            end
            B_CPY: begin
                n_state = B_CPYW;
            end
            B_CPYW: begin
                ch_we = 1'b1;
                if (r_c == i_count - CNT_W'(1)) begin
                    st_we    = 1'b1;
                    st_wdata = SS_USED;
                    len_we   = 1'b1;
                    n_res    = R_INSERTED;
                    n_pos    = POS_W'(r_j);
                    n_state  = B_DONE;
                end else begin
                    n_c     = r_c + CNT_W'(1);
                    n_state = B_CPY;
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_pos   = r_pos;
                    o_pop       = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_rem_a   <= n_rem_a;
        r_rem_b   <= n_rem_b;
        r_j       <= n_j;
        r_stride  <= n_stride;
        r_i       <= n_i;
        r_c       <= n_c;
        r_res     <= n_res;
        r_pos     <= n_pos;
        r_out_res <= n_out_res;
        r_out_pos <= n_out_pos;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_pos, r_out_res};

    `AST_NEXT(a_pop_loads_out, i_clk, i_rst_n, o_pop, o_m_tvalid, "pop without result")
    `AST_IMP(a_probe_bound, i_clk, i_rst_n, r_state == B_CHK, SW'(r_i) < m, "probe past m")

endmodule

// ===== rtl/double_hash_name_table.sv =====
`timescale 1ns / 1ps
// Open-addressing name table with double hashing.
// Input stream: one name character per transaction in i_s_tdata, tlast on
// the final character, operation (insert, search, remove) in i_s_tuser,
// taken with the final character. Output stream: one result transaction
// per name, status and slot position in o_m_tdata.
// Characters are taken one per cycle while o_s_tready is high. After the
// final character the back end works out the two hash remainders one key
// bit at a time, then reads and checks each probe slot and walks the
// characters for each compare or slot copy; the probe sequencer sets the rate.
// A two-entry command queue with a name buffer bank per entry lets the
// next name stream in while the current one is probed.
// After reset a clearing pass empties all SLOTS slot states and
// the input is held not ready. The table size register resets to 64.
// When the receiver stalls, one result waits in the output register, the
// back end holds the next one, and input stops once the queue is full.
module double_hash_name_table
    import dht_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int MAX_NAME = MAX_NAME_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [6:0] name_byte, [7] zero
    input  logic [1:0]       i_s_tuser,   // [1:0] kind
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,   // [2:0] status, [8:3] position, [15:9] zero
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int KEY_W = $clog2(MAX_NAME * 127 + 1);
    localparam int CNT_W = $clog2(MAX_NAME + 1);
    localparam int NB_W  = $clog2(2 * MAX_NAME);

    logic [CFG_W-1:0]  r_table_size;
    t_q_stat           qstat;
    logic              push, pop, over_in, over_hd, wr_bank, rd_bank, clearing;
    t_kind             kind_in, kind_hd;
    logic [KEY_W-1:0]  key_in, key_hd;
    logic [CNT_W-1:0]  cnt_in, cnt_hd;
    logic              buf_we;
    logic [NB_W-1:0]   buf_waddr, buf_raddr;
    logic [BYTE_W-1:0] buf_wdata, buf_rdata;

    // Table size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    dht_front #(.MAX_NAME(MAX_NAME), .KEY_W(KEY_W), .CNT_W(CNT_W), .NB_W(NB_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_byte(i_s_tdata[BYTE_W-1:0]), .i_last(i_s_tlast), .i_kind(t_kind'(i_s_tuser)),
        .i_qstat(qstat), .i_bank(wr_bank), .i_clearing(clearing), .o_push(push),
        .o_kind(kind_in), .o_key(key_in), .o_count(cnt_in), .o_over(over_in),
        .o_buf_we(buf_we), .o_buf_waddr(buf_waddr), .o_buf_wdata(buf_wdata)
    );

    dht_ram #(.W(BYTE_W), .D(2 * MAX_NAME)) u_name_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_raddr(buf_raddr), .o_rdata(buf_rdata)
    );

    dht_queue #(.KEY_W(KEY_W), .CNT_W(CNT_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_kind(kind_in),
        .i_key(key_in), .i_count(cnt_in), .i_over(over_in), .i_pop(pop),
        .o_stat(qstat), .o_wr_bank(wr_bank), .o_rd_bank(rd_bank), .o_kind(kind_hd),
        .o_key(key_hd), .o_count(cnt_hd), .o_over(over_hd)
    );

    dht_back #(
        .SLOTS(SLOTS), .MAX_NAME(MAX_NAME), .KEY_W(KEY_W), .CNT_W(CNT_W), .NB_W(NB_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_table_size(r_table_size), .i_qstat(qstat),
        .i_kind(kind_hd), .i_key(key_hd), .i_count(cnt_hd), .i_over(over_hd),
        .i_rd_bank(rd_bank), .o_pop(pop), .o_clearing(clearing),
        .o_buf_raddr(buf_raddr), .i_buf_rdata(buf_rdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

endmodule
